[hw/rtl/assert_macros.svh]
// Assertion helpers; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/mrmw_pkg.sv]
package mrmw_pkg;

   localparam int unsigned STORE_WORDS  = 1024;
   localparam int unsigned STORE_ADDR_W = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

   localparam int unsigned OFFSET_W = 16;
   localparam int unsigned OP_W     = 4;
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned BUF_W    = 13;
   localparam int unsigned INDEX_W  = OFFSET_W - 2;

   localparam logic [BUF_W-1:0] BUF_RESET = 13'd4096;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_INVALID = 1'b1;

   localparam int unsigned QUEUE_DEPTH = 3;
   localparam int unsigned QUEUE_PTR_W = 2;
   localparam int unsigned QUEUE_CNT_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_ADD  = 4'd0,
      OP_SUB  = 4'd1,
      OP_XCHG = 4'd2,
      OP_UMIN = 4'd3,
      OP_UMAX = 4'd4,
      OP_AND  = 4'd5,
      OP_OR   = 4'd6,
      OP_XOR  = 4'd7
   } atomic_op_type;

   typedef struct packed {
      logic [WORD_W-1:0] old_value;
      logic              status;
      logic [WORD_W-1:0] ops_done;
   } rsp_beat_type;

   typedef struct packed {
      logic [QUEUE_CNT_W-1:0] count;
   } queue_status_type;

endpackage

[hw/rtl/mrmw_ifs.sv]
interface mrmw_req_if import mrmw_pkg::*; ;
   logic                valid;
   logic                ready;
   logic [OFFSET_W-1:0] byte_offset;
   logic [OP_W-1:0]     atomic_op;
   logic [WORD_W-1:0]   operand;

   modport source (output valid, byte_offset, atomic_op, operand, input ready);
   modport sink   (input valid, byte_offset, atomic_op, operand, output ready);
endinterface

interface mrmw_rsp_if import mrmw_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] old_value;
   logic              status;
   logic [WORD_W-1:0] ops_done;

   modport source (output valid, old_value, status, ops_done, input ready);
   modport sink   (input valid, old_value, status, ops_done, output ready);
endinterface

interface mrmw_csr_if import mrmw_pkg::*; ;
   logic             valid;
   logic             ready;
   logic [BUF_W-1:0] buffer_bytes;

   modport source (output valid, buffer_bytes, input ready);
   modport sink   (input valid, buffer_bytes, output ready);
endinterface

[hw/rtl/memory_atomic_rmw_unit.sv]
// Atomic read-modify-write unit over a store of STORE_WORDS 32-bit words.
// A request beat carries a byte offset (low two bits ignored), an operation
// (add, sub, xchg, umin, umax, and, or, xor) and an operand; each request
// gives exactly one response beat with the old word, a status and the
// running count of successful operations. Requests with an offset at or
// above buffer_bytes, a word index beyond the store, or an operation code
// of 8 or more are answered with status 1 and old value 0 and change
// nothing. The block takes one request per cycle while the response side
// keeps up. A response beat passes through the execute stage register and
// the response queue before it is presented. The store has a single
// registered read port: the word is read at accept, combined in the next
// cycle and written back at its end. A request that hits the word written
// back in the same cycle as its read takes the data from a forwarding
// register, so back-to-back operations on one word see each other. A
// three-beat response queue decouples the response side. Request ready
// drops while the queue and the execute stage together hold three beats,
// so a stalled response side stalls requests after that many. The store
// needs no clearing pass after reset: a word must be written before it is
// read. buffer_bytes is written through the csr channel; the user must do
// so only while the block is idle, the block does not enforce it.
`include "assert_macros.svh"

module memory_atomic_rmw_unit import mrmw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   mrmw_csr_if.sink   csr,
   mrmw_req_if.sink   req,
   mrmw_rsp_if.source rsp
);

   // Configuration register
   logic [BUF_W-1:0] buf_bytes_ff;

   // Request decode
   logic                    req_fire;
   logic [INDEX_W-1:0]      word_idx;
   logic                    req_ok;

   // Execute stage
   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_ok_ff;
   logic [STORE_ADDR_W-1:0] s1_addr_ff;
   atomic_op_type           s1_op_ff;
   logic [WORD_W-1:0]       s1_operand_ff;

   // Write-back forwarding
   logic                    fwd_valid_ff, fwd_valid_in;
   logic [STORE_ADDR_W-1:0] fwd_addr_ff;
   logic [WORD_W-1:0]       fwd_data_ff;

   logic [WORD_W-1:0]       cnt_ff, cnt_in;
   logic [WORD_W-1:0]       ram_rdata;
   logic [WORD_W-1:0]       old_word;
   logic [WORD_W-1:0]       new_word;
   logic                    wr_en;
   rsp_beat_type            s1_beat;
   queue_status_type        q_stat;

   // Config channel is always ready; the user must send writes only while idle, the block does not enforce it.
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_bytes_ff <= BUF_RESET;
      end else if (csr.valid && csr.ready) begin
         buf_bytes_ff <= csr.buffer_bytes;
      end
   end

   // Leave room in the queue for the beat in the execute stage and this one.
   assign req.ready = ({1'b0, q_stat.count} + (QUEUE_CNT_W + 1)'(s1_valid_ff))
                      < (QUEUE_CNT_W + 1)'(QUEUE_DEPTH);
   assign req_fire  = req.valid && req.ready;

   // Range checks use the full offset; the word index drops the byte bits.
   assign word_idx = req.byte_offset[OFFSET_W-1:2];
   assign req_ok   = (req.byte_offset < {{(OFFSET_W - BUF_W){1'b0}}, buf_bytes_ff})
                     && ({1'b0, word_idx} < (INDEX_W + 1)'(STORE_WORDS))
                     && (req.atomic_op <= OP_XOR);

   assign s1_valid_in = req_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Payload of the execute stage: advance on every accepted beat.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ok_ff      <= req_ok;
         s1_addr_ff    <= word_idx[STORE_ADDR_W-1:0];
         s1_op_ff      <= atomic_op_type'(req.atomic_op);
         s1_operand_ff <= req.operand;
      end
   end

   // Write back only successful operations.
   assign wr_en = s1_valid_ff && s1_ok_ff;

   mrmw_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STORE_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (new_word),
      .rd_en   (req_fire && req_ok),
      .rd_addr (word_idx[STORE_ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   // Remember the write of this cycle; the read issued at the same edge
   // misses it.
   assign fwd_valid_in = wr_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         fwd_addr_ff <= s1_addr_ff;
         fwd_data_ff <= new_word;
      end
   end

   assign old_word = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff : ram_rdata;

   mrmw_alu u_alu (
      .op       (s1_op_ff),
      .old_word (old_word),
      .operand  (s1_operand_ff),
      .new_word (new_word)
   );

   // Success counter: bump on each write back, report the updated count.
   assign cnt_in = wr_en ? cnt_ff + 1'b1 : cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_comb begin
      s1_beat.old_value = s1_ok_ff ? old_word : '0;
      s1_beat.status    = s1_ok_ff ? STATUS_OK : STATUS_INVALID;
      s1_beat.ops_done  = cnt_in;
   end

   mrmw_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff),
      .push_beat (s1_beat),
      .rsp       (rsp),
      .status    (q_stat)
   );

   `ASSERT_IMPLY(a_queue_room, clock, reset, s1_valid_ff, q_stat.count < QUEUE_CNT_W'(QUEUE_DEPTH))
   `ASSERT_NEXT(a_count_step, clock, reset, wr_en, cnt_ff == $past(cnt_ff) + 1'b1)
   `ASSERT_NEXT(a_count_hold, clock, reset, !wr_en, cnt_ff == $past(cnt_ff))
   `ASSERT_NEXT(a_fwd_track, clock, reset, wr_en, fwd_valid_ff && (fwd_addr_ff == $past(s1_addr_ff)))

endmodule

[hw/rtl/mrmw_ram.sv]
module mrmw_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/mrmw_alu.sv]
module mrmw_alu import mrmw_pkg::*; (
   input  atomic_op_type     op,
   input  logic [WORD_W-1:0] old_word,
   input  logic [WORD_W-1:0] operand,
   output logic [WORD_W-1:0] new_word
);

   always_comb begin
      case (op)
         OP_ADD:  new_word = old_word + operand;
         OP_SUB:  new_word = old_word - operand;
         OP_XCHG: new_word = operand;
         OP_UMIN: new_word = (old_word < operand) ? old_word : operand;
         OP_UMAX: new_word = (old_word > operand) ? old_word : operand;
         OP_AND:  new_word = old_word & operand;
         OP_OR:   new_word = old_word | operand;
         default: new_word = old_word ^ operand;
      endcase
   end

endmodule

[hw/rtl/mrmw_rsp_queue.sv]
module mrmw_rsp_queue import mrmw_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rsp_beat_type     push_beat,
   mrmw_rsp_if.source       rsp,
   output queue_status_type status
);

   rsp_beat_type           entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] head_ff, head_in;
   logic [QUEUE_PTR_W-1:0] tail_ff, tail_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   pop;

   function automatic logic [QUEUE_PTR_W-1:0] ptr_next(input logic [QUEUE_PTR_W-1:0] ptr);
      return (ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   assign pop = rsp.valid && rsp.ready;

   always_comb begin
      head_in  = pop  ? ptr_next(head_ff) : head_ff;
      tail_in  = push ? ptr_next(tail_ff) : tail_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[tail_ff] <= push_beat;
      end
   end

   assign rsp.valid     = (count_ff != '0);
   assign rsp.old_value = entries_ff[head_ff].old_value;
   assign rsp.status    = entries_ff[head_ff].status;
   assign rsp.ops_done  = entries_ff[head_ff].ops_done;
   assign status.count  = count_ff;

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import mrmw_pkg::*;

   typedef struct {
      logic [OFFSET_W-1:0] byte_offset;
      logic [OP_W-1:0]     atomic_op;
      logic [WORD_W-1:0]   operand;
   } rmw_request_type;

   // old_known is clear when the word was opened by its first exchange:
   // its prior contents are undefined, so only status and count are checked
   typedef struct {
      logic [WORD_W-1:0] old_value;
      bit                old_known;
      logic              status;
      logic [WORD_W-1:0] ops_done;
   } rmw_answer_type;

   localparam logic [OP_W-1:0] OP_CODE_MAX = '1;
   localparam int unsigned OFFSET_MAX  = (1 << OFFSET_W) - 1;
   localparam int unsigned BUF_MAX     = (1 << BUF_W) - 1;
   localparam int unsigned STORE_BYTES = STORE_WORDS * 4;
   localparam int unsigned NUM_PHASES  = 10;
   localparam int          RANDOM_BUF  = -1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mrmw_csr_if csr_bus ();
   mrmw_req_if req_bus ();
   mrmw_rsp_if rsp_bus ();

   memory_atomic_rmw_unit DUT (
      .clock (clock),
      .reset (reset),
      .csr   (csr_bus),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   always #1 clock = ~clock;

   // Buffer size per phase (the first keeps the reset value), random beats
   // per phase, and whether both sides may idle during the phase.
   int phase_buf   [NUM_PHASES] = '{4096, 8191, 0, 1, 4, 64, 4096, RANDOM_BUF, 2048, 4096};
   int phase_beats [NUM_PHASES] = '{100, 150, 40, 60, 60, 150, 300, 200, 150, 240};
   bit phase_idle  [NUM_PHASES] = '{1, 1, 1, 0, 1, 1, 0, 1, 1, 0};

   rmw_request_type pending_requests [$];
   rmw_answer_type  awaited_answers [$];

   // Predictor state: the word store as the block should hold it
   logic [WORD_W-1:0] shadow_words [STORE_WORDS];
   bit                shadow_known [STORE_WORDS];
   logic [WORD_W-1:0] shadow_ops = '0;
   logic [BUF_W-1:0]  shadow_buf = BUF_RESET;

   // Generator view: which words have been opened, and the buffer size that
   // will be in force when the queued beats go out
   bit          gen_written [STORE_WORDS];
   int unsigned gen_buf  = BUF_RESET;
   int unsigned last_ofs = 0;

   bit idle_enable = 1'b0;
   int req_gap_left   = 0;
   int rsp_stall_left = 0;
   int mismatch_count = 0;

   // Work out the answer to one accepted request and advance the store.
   task automatic apply_rmw(input rmw_request_type r);
      rmw_answer_type    a;
      int unsigned       word;
      logic [WORD_W-1:0] old;
      word = 32'(r.byte_offset >> 2);
      a.old_value = '0;
      a.old_known = 1'b1;
      a.status    = STATUS_INVALID;
      if (r.byte_offset < shadow_buf && word < STORE_WORDS && r.atomic_op <= OP_XOR) begin
         old = shadow_words[word];
         a.old_value = old;
         a.old_known = shadow_known[word];
         a.status    = STATUS_OK;
         case (atomic_op_type'(r.atomic_op))
            OP_ADD:  shadow_words[word] = old + r.operand;
            OP_SUB:  shadow_words[word] = old - r.operand;
            OP_XCHG: shadow_words[word] = r.operand;
            OP_UMIN: shadow_words[word] = (old < r.operand) ? old : r.operand;
            OP_UMAX: shadow_words[word] = (old > r.operand) ? old : r.operand;
            OP_AND:  shadow_words[word] = old & r.operand;
            OP_OR:   shadow_words[word] = old | r.operand;
            default: shadow_words[word] = old ^ r.operand;
         endcase
         shadow_known[word] = 1'b1;
         shadow_ops = shadow_ops + 1'b1;
      end
      a.ops_done = shadow_ops;
      awaited_answers.push_back(a);
   endtask

   // Queue one request. A valid request to a word never written is turned
   // into an exchange, so no beat computes a new word from undefined contents.
   task automatic queue_request(input int unsigned ofs, input logic [OP_W-1:0] op,
                                input logic [WORD_W-1:0] val);
      rmw_request_type r;
      int unsigned     word;
      word = ofs >> 2;
      if (ofs < gen_buf && word < STORE_WORDS && op <= OP_XOR) begin
         if (!gen_written[word]) op = OP_XCHG;
         gen_written[word] = 1'b1;
      end
      r.byte_offset = OFFSET_W'(ofs);
      r.atomic_op   = op;
      r.operand     = val;
      pending_requests.push_back(r);
   endtask

   function automatic logic [WORD_W-1:0] pick_operand();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return {1'b1, {(WORD_W-1){1'b0}}};
         3:       return {1'b0, {(WORD_W-1){1'b1}}};
         4:       return $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   task automatic random_request();
      int unsigned     span;
      int unsigned     pick;
      int unsigned     ofs;
      logic [OP_W-1:0] op;
      span = (gen_buf < STORE_BYTES) ? gen_buf : STORE_BYTES;
      pick = $urandom_range(0, 99);
      op   = OP_W'($urandom_range(0, OP_XOR));
      if (pick < 10 || span == 0) begin
         // past the usable span: rejected by size or by store depth
         ofs = $urandom_range(span, OFFSET_MAX);
      end else if (pick < 20) begin
         ofs = $urandom_range(0, OFFSET_MAX);
         op  = OP_W'($urandom_range(OP_XOR + 1, OP_CODE_MAX));
      end else if (pick < 50 && last_ofs < span) begin
         // hit the same word again to exercise forwarding
         ofs = (last_ofs & ~32'd3) | $urandom_range(0, 3);
      end else begin
         ofs = $urandom_range(0, span - 1);
      end
      last_ofs = ofs;
      queue_request(ofs, op, pick_operand());
   endtask

   // Hold until every queued beat is sent and answered, then settle.
   task automatic drain();
      while (pending_requests.size() != 0 || req_bus.valid || awaited_answers.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Request driver: pop the next beat once the current one is taken,
   // with random idle bursts after a beat.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid       <= 1'b0;
         req_bus.byte_offset <= '0;
         req_bus.atomic_op   <= '0;
         req_bus.operand     <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            apply_rmw('{req_bus.byte_offset, req_bus.atomic_op, req_bus.operand});
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap_left != 0) begin
               req_gap_left--;
               req_bus.valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               req_bus.valid       <= 1'b1;
               req_bus.byte_offset <= pending_requests[0].byte_offset;
               req_bus.atomic_op   <= pending_requests[0].atomic_op;
               req_bus.operand     <= pending_requests[0].operand;
               void'(pending_requests.pop_front());
               if (idle_enable && $urandom_range(0, 99) < 12)
                  req_gap_left = $urandom_range(1, 9);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: compare each beat with the oldest expectation and
   // stall ready in random bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_answers.size() == 0) begin
               $error("response beat with nothing outstanding: old_value %h status %b ops_done %0d",
                      rsp_bus.old_value, rsp_bus.status, rsp_bus.ops_done);
               mismatch_count++;
            end else begin
               if (awaited_answers[0].old_known &&
                   rsp_bus.old_value !== awaited_answers[0].old_value) begin
                  $error("old_value: expected %h, got %h",
                         awaited_answers[0].old_value, rsp_bus.old_value);
                  mismatch_count++;
               end
               if (rsp_bus.status !== awaited_answers[0].status) begin
                  $error("status: expected %b, got %b",
                         awaited_answers[0].status, rsp_bus.status);
                  mismatch_count++;
               end
               if (rsp_bus.ops_done !== awaited_answers[0].ops_done) begin
                  $error("ops_done: expected %0d, got %0d",
                         awaited_answers[0].ops_done, rsp_bus.ops_done);
                  mismatch_count++;
               end
               void'(awaited_answers.pop_front());
            end
         end
         if (rsp_stall_left != 0) begin
            rsp_stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 99) < 10) begin
            rsp_stall_left = $urandom_range(1, 9) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      int unsigned new_buf;
      csr_bus.valid        = 1'b0;
      csr_bus.buffer_bytes = BUF_RESET;
      req_bus.valid        = 1'b0;
      req_bus.byte_offset  = '0;
      req_bus.atomic_op    = '0;
      req_bus.operand      = '0;
      rsp_bus.ready        = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain();
         if (p != 0) begin
            new_buf = (phase_buf[p] == RANDOM_BUF) ? $urandom_range(1, BUF_MAX) : phase_buf[p];
            // write the buffer size while nothing is in flight
            csr_bus.valid        <= 1'b1;
            csr_bus.buffer_bytes <= BUF_W'(new_buf);
            do @(posedge clock); while (!csr_bus.ready);
            csr_bus.valid <= 1'b0;
            shadow_buf = BUF_W'(new_buf);
            gen_buf    = new_buf;
         end
         idle_enable = phase_idle[p];

         if (p == 0) begin
            // every operation on word 0, wrap on add and sub, unsigned
            // compare on min and max, ignored low offset bits
            queue_request(0, OP_XCHG, 32'hFFFF_FFFF);
            queue_request(0, OP_ADD,  32'd1);
            queue_request(1, OP_SUB,  32'd1);
            queue_request(2, OP_UMIN, 32'h7FFF_FFFF);
            queue_request(3, OP_UMAX, 32'h8000_0000);
            queue_request(0, OP_AND,  32'hC000_0000);
            queue_request(1, OP_OR,   32'h0000_FFFF);
            queue_request(2, OP_XOR,  32'hFFFF_FFFF);
            queue_request(3, OP_UMAX, 32'd0);
            queue_request(0, OP_UMIN, 32'hFFFF_FFFF);
            queue_request(0, OP_XCHG, 32'd0);
            // last word of the store, then rejections by size and by op code
            queue_request(STORE_BYTES - 1, OP_XCHG, 32'h1234_5678);
            queue_request(STORE_BYTES - 4, OP_ADD,  32'hFFFF_FFFF);
            queue_request(STORE_BYTES, OP_ADD, 32'd1);
            queue_request(OFFSET_MAX, OP_XOR, 32'hFFFF_FFFF);
            queue_request(0, OP_W'(OP_XOR + 1), 32'd5);
            queue_request(STORE_BYTES - 4, OP_CODE_MAX, 32'd5);
         end else begin
            // both sides of the configured size and of the store depth
            if (gen_buf != 0) queue_request(gen_buf - 1, OP_ADD, pick_operand());
            queue_request(gen_buf, OP_ADD, pick_operand());
            queue_request(STORE_BYTES - 4, OP_OR, pick_operand());
            queue_request(STORE_BYTES, OP_XCHG, pick_operand());
            queue_request(0, OP_SUB, pick_operand());
         end
         repeat (phase_beats[p]) random_request();
      end

      drain();
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
